### rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and codes for the mouse packet decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 10;
  localparam int unsigned StepW  = 4;
  localparam int unsigned BtnN   = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_WHEEL_EN = 2'd0;
  localparam logic [1:0] CFG_FIVE_EN  = 2'd1;

  // event kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_MOTION = 2'd1;
  localparam logic [1:0] KIND_SYNC   = 2'd2;

  // event codes
  localparam logic [2:0] CODE_LEFT   = 3'd0;
  localparam logic [2:0] CODE_RIGHT  = 3'd1;
  localparam logic [2:0] CODE_MIDDLE = 3'd2;
  localparam logic [2:0] CODE_SIDE   = 3'd3;
  localparam logic [2:0] CODE_EXTRA  = 3'd4;
  localparam logic [2:0] CODE_X      = 3'd0;
  localparam logic [2:0] CODE_Y      = 3'd1;
  localparam logic [2:0] CODE_WHEEL  = 3'd2;
  localparam logic [2:0] CODE_NONE   = 3'd0;

  // sequencer steps of the back end
  localparam logic [StepW-1:0] STEP_LEFT   = 4'd0;
  localparam logic [StepW-1:0] STEP_RIGHT  = 4'd1;
  localparam logic [StepW-1:0] STEP_MIDDLE = 4'd2;
  localparam logic [StepW-1:0] STEP_SIDE   = 4'd3;
  localparam logic [StepW-1:0] STEP_EXTRA  = 4'd4;
  localparam logic [StepW-1:0] STEP_X      = 4'd5;
  localparam logic [StepW-1:0] STEP_Y      = 4'd6;
  localparam logic [StepW-1:0] STEP_WHEEL  = 4'd7;
  localparam logic [StepW-1:0] STEP_SYNC   = 4'd8;

  // one completed packet
  typedef struct packed {
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
    logic             wheel;
    logic             five;
  } pmd_pkt_t;

  // front end to queue
  typedef struct packed {
    logic     push;
    pmd_pkt_t pkt;
  } pmd_push_t;

endpackage

### rtl/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front
// Byte assembler: resyncs on bit 3 of the first byte, collects a packet.
// ----------------------------------------------------------------------------
module pmd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [pmd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                    wheel_en_i,
  input  logic                    five_en_i,
  output pmd_pkg::pmd_push_t      push_o
);
  import pmd_pkg::*;

  logic [1:0]       pos_q, pos_d;
  logic [ByteW-1:0] pb_q [3];
  logic             drop, store, done;

  always_comb begin
    drop  = (pos_q == 2'd0) && !rx_byte_i[3];
    // packet ends after byte two with the wheel off, or after byte three
    done  = !drop && ((pos_q == 2'd3) || ((pos_q == 2'd2) && !wheel_en_i));
    store = !drop && !done;
    pos_d = pos_q;
    if (accept_i) begin
      if (store) begin
        pos_d = pos_q + 2'd1;
      end else begin
        pos_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store) begin
      pb_q[pos_q] <= rx_byte_i;
    end
  end

  always_comb begin
    push_o.push      = accept_i && done;
    push_o.pkt.b0    = pb_q[0];
    push_o.pkt.b1    = pb_q[1];
    push_o.pkt.b2    = (pos_q == 2'd2) ? rx_byte_i : pb_q[2];
    push_o.pkt.b3    = wheel_en_i ? rx_byte_i : '0;
    push_o.pkt.wheel = wheel_en_i;
    push_o.pkt.five  = five_en_i;
  end

endmodule

### rtl/pmd_pkt_fifo.sv
// ----------------------------------------------------------------------------
// pmd_pkt_fifo
// Two-entry packet queue between the assembler and the event sequencer.
// ----------------------------------------------------------------------------
module pmd_pkt_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmd_pkg::pmd_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               nonempty_o,
  output pmd_pkg::pmd_pkt_t  head_o
);
  import pmd_pkg::*;

  pmd_pkt_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign nonempty_o = (cnt_q != 2'd0);
  assign do_push    = push_i.push && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.pkt;
    end
  end

endmodule

### rtl/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back
// Event sequencer: walks the nine event slots of a packet, one per cycle
// unless an event waits on the output register, and keeps the button state.
// ----------------------------------------------------------------------------
module pmd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pkt_valid_i,
  input  pmd_pkg::pmd_pkt_t                pkt_i,
  output logic                             pkt_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [1:0]                       event_kind_o,
  output logic [2:0]                       event_code_o,
  output logic signed [pmd_pkg::ValueW-1:0] event_value_o,
  output logic                             last_event_o
);
  import pmd_pkg::*;

  logic [StepW-1:0]  step_q;
  logic [BtnN-1:0]   btn_q;
  logic              out_valid_q;
  logic [1:0]        kind_q;
  logic [2:0]        code_q;
  logic [ValueW-1:0] value_q;
  logic              last_q;

  logic              emit, is_btn, pressed, out_free, advance;
  logic [2:0]        btn_idx;
  logic [1:0]        kind;
  logic [2:0]        code;
  logic [ValueW-1:0] value, x_val, y_val, w_val;

  always_comb begin
    x_val = {pkt_i.b0[4], pkt_i.b0[4], pkt_i.b1};
    y_val = ValueW'(0) - {pkt_i.b0[5], pkt_i.b0[5], pkt_i.b2};
    w_val = {6'd0, pkt_i.b3[3], 3'd0} - {7'd0, pkt_i.b3[2:0]};
  end

  always_comb begin
    emit    = 1'b0;
    is_btn  = 1'b0;
    pressed = 1'b0;
    btn_idx = step_q[2:0];
    kind    = KIND_KEY;
    code    = step_q[2:0];
    value   = '0;
    case (step_q)
      STEP_LEFT: begin
        is_btn  = 1'b1;
        pressed = pkt_i.b0[0];
      end
      STEP_RIGHT: begin
        is_btn  = 1'b1;
        pressed = pkt_i.b0[1];
      end
      STEP_MIDDLE: begin
        is_btn  = 1'b1;
        pressed = pkt_i.b0[2];
      end
      STEP_SIDE: begin
        is_btn  = pkt_i.five;
        pressed = pkt_i.b3[4];
      end
      STEP_EXTRA: begin
        is_btn  = pkt_i.five;
        pressed = pkt_i.b3[5];
      end
      STEP_X: begin
        kind  = KIND_MOTION;
        code  = CODE_X;
        value = x_val;
        emit  = (x_val != '0);
      end
      STEP_Y: begin
        kind  = KIND_MOTION;
        code  = CODE_Y;
        value = y_val;
        emit  = (y_val != '0);
      end
      STEP_WHEEL: begin
        kind  = KIND_MOTION;
        code  = CODE_WHEEL;
        value = w_val;
        emit  = pkt_i.wheel && (w_val != '0);
      end
      STEP_SYNC: begin
        kind = KIND_SYNC;
        code = CODE_NONE;
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (is_btn) begin
      emit  = (pressed != btn_q[btn_idx]);
      value = {{(ValueW-1){1'b0}}, pressed};
    end
  end

  assign out_free  = !out_valid_q || pop_i;
  assign advance   = pkt_valid_i && (!emit || out_free);
  assign pkt_pop_o = advance && (step_q == STEP_SYNC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_LEFT;
      btn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q <= (step_q == STEP_SYNC) ? STEP_LEFT : step_q + 4'd1;
        if (is_btn && emit) begin
          btn_q[btn_idx] <= pressed;
        end
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q  <= kind;
      code_q  <= code;
      value_q <= value;
      last_q  <= (step_q == STEP_SYNC);
    end
  end

  assign empty_o       = !out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_code_o  = code_q;
  assign event_value_o = value_q;
  assign last_event_o  = last_q;

endmodule

### rtl/ps2_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// PS/2 mouse packet decoder with wheel and five-button support.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle into the assembler while full is low; a
// finished packet goes into a two-entry queue, and the event sequencer walks
// the nine event slots of the oldest packet (five buttons, x, y, wheel, sync)
// at one slot per cycle whether or not a slot produces an event, unless an
// event waits for the output register. full rises only while the packet queue
// holds two packets. Events sit in one output register, refilled in the cycle
// it is popped. The configuration registers sit behind cfg_ready_o, which is
// always high; wheel and five-button mode are sampled when a packet ends.
module ps2_mouse_packet_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [pmd_pkg::ByteW-1:0]          rx_byte_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         event_kind_o,
  output logic [2:0]                         event_code_o,
  output logic signed [pmd_pkg::ValueW-1:0]  event_value_o,
  output logic                               last_event_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic                               cfg_data_i
);
  import pmd_pkg::*;

  logic      wheel_en_q, five_en_q;
  logic      accept;
  pmd_push_t push_w;
  pmd_pkt_t  head;
  logic      q_full, q_nonempty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_en_q <= 1'b0;
      five_en_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_WHEEL_EN) begin
        wheel_en_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_FIVE_EN) begin
        five_en_q <= cfg_data_i;
      end
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  pmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .wheel_en_i (wheel_en_q),
    .five_en_i  (five_en_q),
    .push_o     (push_w)
  );

  pmd_pkt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_w),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head)
  );

  pmd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_valid_i   (q_nonempty),
    .pkt_i         (head),
    .pkt_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .event_kind_o  (event_kind_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o)
  );

endmodule

### rtl/pmd_checker.sv
// ----------------------------------------------------------------------------
// pmd_checker
// Port-level checks on the event stream of the decoder.
// ----------------------------------------------------------------------------
module pmd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [1:0]        event_kind_o,
  input logic [2:0]        event_code_o,
  input logic signed [9:0] event_value_o,
  input logic              last_event_o
);
  import pmd_pkg::*;

  // last word of a packet is always the sync event and vice versa
  a_last_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_event_o == (event_kind_o == KIND_SYNC)))
    else $error("last_event does not match sync");

  a_key_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == KIND_KEY) |->
      ((event_value_o == 10'sd0 || event_value_o == 10'sd1) &&
       event_code_o <= CODE_EXTRA))
    else $error("bad key event");

  a_motion_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_kind_o == KIND_MOTION) |->
      (event_value_o != 10'sd0 && event_code_o <= CODE_WHEEL))
    else $error("zero or bad motion event");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(event_kind_o) &&
      $stable(event_code_o) && $stable(event_value_o)))
    else $error("word changed while stalled");

endmodule

bind ps2_mouse_packet_decoder_core pmd_checker u_pmd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .event_kind_o  (event_kind_o),
  .event_code_o  (event_code_o),
  .event_value_o (event_value_o),
  .last_event_o  (last_event_o)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 mouse packet decoder core. Mouse bytes go
// in through the push/full side, decoded events come out through the
// empty/pop side and are compared field by field against a cycle-free model
// of packet assembly, button tracking and motion decode, across all
// wheel/five-button mode settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  localparam logic [1:0] CFG_SPARE_A    = 2'd2;
  localparam logic [1:0] CFG_SPARE_B    = 2'd3;
  localparam int         BASE_BUTTONS   = 3;
  localparam int         SETTLE_CYCLES  = 32;
  localparam int         END_CYCLES     = 40;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_REPORTS    = 20;

  typedef struct packed {
    logic [1:0]               kind;
    logic [2:0]               code;
    logic signed [ValueW-1:0] value;
    logic                     last;
  } mouse_event_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              push        = 1'b0;
  logic              full;
  logic [ByteW-1:0]  rx_byte_i   = '0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [1:0]        event_kind_o;
  logic [2:0]        event_code_o;
  logic signed [ValueW-1:0] event_value_o;
  logic              last_event_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic              cfg_data_i  = 1'b0;

  ps2_mouse_packet_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .event_kind_o  (event_kind_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // decoder model state
  logic             mode_wheel;
  logic             mode_five;
  int               asm_pos;
  logic [ByteW-1:0] asm_bytes [3];
  logic [BtnN-1:0]  btn_state;
  mouse_event_t     pending_events [$];

  int  errors        = 0;
  int  bytes_sent    = 0;
  int  events_seen   = 0;
  int  reg_writes    = 0;
  bit  calm          = 1'b0;
  int  pop_gap       = 0;
  int  idle_cycles   = 0;

  logic [2:0] key_codes [BtnN] = '{CODE_LEFT, CODE_RIGHT, CODE_MIDDLE, CODE_SIDE, CODE_EXTRA};

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void queue_event(input logic [1:0] kind, input logic [2:0] code,
                                      input int v, input logic last);
    mouse_event_t ev;
    ev.kind  = kind;
    ev.code  = code;
    ev.value = v[ValueW-1:0];
    ev.last  = last;
    pending_events.push_back(ev);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic data);
    case (idx)
      CFG_WHEEL_EN: mode_wheel = data;
      CFG_FIVE_EN:  mode_five  = data;
      default: ;
    endcase
  endfunction

  // assembles packets and queues the events a completed one produces
  function automatic void predict_mouse_events(input logic [ByteW-1:0] b);
    int               len;
    int               x;
    int               y;
    int               w;
    logic [ByteW-1:0] b3;
    logic [BtnN-1:0]  btn_next;
    len = mode_wheel ? 4 : 3;
    if (asm_pos == 0 && !b[3]) return;
    if (asm_pos + 1 < len) begin
      asm_bytes[asm_pos] = b;
      asm_pos++;
      return;
    end
    // wheel switched off at position three: this word just ends the packet
    if (asm_pos < 3) asm_bytes[asm_pos] = b;
    asm_pos = 0;
    b3 = mode_wheel ? b : '0;
    btn_next = {b3[5], b3[4], asm_bytes[0][2:0]};
    for (int i = 0; i < BtnN; i++) begin
      if ((i < BASE_BUTTONS || mode_five) && btn_next[i] != btn_state[i]) begin
        btn_state[i] = btn_next[i];
        queue_event(KIND_KEY, key_codes[i], btn_next[i] ? 1 : 0, 1'b0);
      end
    end
    x = int'(asm_bytes[1]) - (asm_bytes[0][4] ? 256 : 0);
    if (x != 0) queue_event(KIND_MOTION, CODE_X, x, 1'b0);
    y = int'(asm_bytes[2]) - (asm_bytes[0][5] ? 256 : 0);
    if (y != 0) queue_event(KIND_MOTION, CODE_Y, -y, 1'b0);
    if (mode_wheel) begin
      w = (b3[3] ? 8 : 0) - int'(b3[2:0]);
      if (w != 0) queue_event(KIND_MOTION, CODE_WHEEL, w, 1'b0);
    end
    queue_event(KIND_SYNC, CODE_NONE, 0, 1'b1);
  endfunction

  // drops push, optionally waits for the event queue to drain, then waits
  task automatic rest_sender(input bit until_drained, input int cycles);
    push <= 1'b0;
    if (until_drained) while (pending_events.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_rx_byte(input logic [ByteW-1:0] b);
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    predict_mouse_events(b);
    if (!calm && $urandom_range(0, 3) == 0) rest_sender(1'b0, $urandom_range(1, 5));
  endtask

  task automatic send_bytes(input logic [ByteW-1:0] seq [$]);
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  // leaves cfg_valid_i high, the caller drops it
  task automatic write_reg(input logic [1:0] idx, input logic data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
    apply_reg(idx, data);
  endtask

  task automatic set_modes(input logic wheel, input logic five);
    rest_sender(1'b1, SETTLE_CYCLES);
    write_reg(CFG_WHEEL_EN, wheel);
    write_reg(CFG_FIVE_EN, five);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_basic_packets();
    set_modes(1'b0, 1'b0);
    // first words without the sync bit get dropped
    send_bytes('{8'h00, 8'hF7});
    send_bytes('{8'hFF, 8'h00, 8'h00});
    send_bytes('{8'h0F, 8'hFF, 8'hFF});
    send_bytes('{8'h38, 8'h01, 8'hFF});
  endtask

  task automatic test_wheel_and_side_buttons();
    set_modes(1'b1, 1'b1);
    send_bytes('{8'h08, 8'h00, 8'h00, 8'h30});
    send_bytes('{8'h08, 8'h00, 8'h00, 8'h08});
    send_bytes('{8'h0F, 8'h00, 8'h00, 8'h37});
  endtask

  // no fourth word, so side and extra read as released
  task automatic test_five_button_without_wheel();
    set_modes(1'b0, 1'b1);
    send_bytes('{8'h08, 8'h00, 8'h00});
  endtask

  task automatic test_mode_change_mid_packet();
    set_modes(1'b1, 1'b0);
    send_bytes('{8'h09, 8'h05, 8'h05});
    set_modes(1'b0, 1'b0);
    send_rx_byte(8'hAA);
    send_bytes('{8'h0A, 8'h80});
    set_modes(1'b1, 1'b0);
    send_bytes('{8'h01, 8'hC7});
  endtask

  task automatic test_spare_register_index();
    rest_sender(1'b1, SETTLE_CYCLES);
    write_reg(CFG_SPARE_A, 1'b1);
    write_reg(CFG_SPARE_B, 1'b1);
    cfg_valid_i <= 1'b0;
    send_bytes('{8'h08, 8'h7F, 8'h80, 8'h0F});
  endtask

  task automatic random_phase(input logic wheel, input logic five, input int n_bytes,
                              input bit with_pause);
    int               sent_here;
    int               pick;
    int               len;
    bit               paused;
    logic [ByteW-1:0] b;
    set_modes(wheel, five);
    sent_here = 0;
    paused    = 1'b0;
    while (sent_here < n_bytes) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_rx_byte(8'($urandom_range(0, 255)));
        sent_here++;
      end else if (pick == 1) begin
        // packet cut short, the next packet's words fill it up
        b = 8'($urandom_range(0, 255));
        b[3] = 1'b1;
        send_rx_byte(b);
        send_rx_byte(8'($urandom_range(0, 255)));
        sent_here += 2;
      end else begin
        len = mode_wheel ? 4 : 3;
        for (int j = 0; j < len; j++) begin
          b = 8'($urandom_range(0, 255));
          if (j == 0) b[3] = 1'b1;
          else if ($urandom_range(0, 3) == 0) b = '0;
          send_rx_byte(b);
        end
        sent_here += len;
      end
      if (with_pause && !paused && sent_here >= n_bytes / 2) begin
        rest_sender(1'b1, 1);
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(1'b0, 1'b0, 35, 1'b0);
    random_phase(1'b1, 1'b1, 35, 1'b1);
    random_phase(1'b0, 1'b1, 35, 1'b0);
    rest_sender(1'b1, SETTLE_CYCLES);
    calm = 1'b1;
    random_phase(1'b1, 1'b0, 35, 1'b0);
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop_gap = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mouse_event_t exp;
    if (rst_ni && pop && !empty) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d code %0d value %0d",
                                  event_kind_o, event_code_o, event_value_o));
      end else begin
        exp = pending_events.pop_front();
        if (event_kind_o !== exp.kind)
          report_mismatch($sformatf("kind %0d, want %0d", event_kind_o, exp.kind));
        if (event_code_o !== exp.code)
          report_mismatch($sformatf("code %0d, want %0d", event_code_o, exp.code));
        if (event_value_o !== exp.value)
          report_mismatch($sformatf("value %0d, want %0d", event_value_o, exp.value));
        if (last_event_o !== exp.last)
          report_mismatch($sformatf("last %0b, want %0b", last_event_o, exp.last));
      end
    end
    // watchdog on cycles without any handshake
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d events still pending", pending_events.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    mode_wheel = 1'b0;
    mode_five  = 1'b0;
    asm_pos    = 0;
    btn_state  = '0;
    foreach (asm_bytes[i]) asm_bytes[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_packets();
    test_wheel_and_side_buttons();
    test_five_button_without_wheel();
    test_mode_change_mid_packet();
    test_spare_register_index();
    test_random_traffic();

    rest_sender(1'b1, END_CYCLES);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
    $display("covered %0d mouse bytes over all wheel/five-button modes, %0d reg writes",
             bytes_sent, reg_writes);
    $display("compared %0d decoded events", events_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pmd_pkg.sv
rtl/pmd_front.sv
rtl/pmd_pkt_fifo.sv
rtl/pmd_back.sv
rtl/ps2_mouse_packet_decoder_core.sv
rtl/pmd_checker.sv
sim/tb.sv
